@@ rtl/sn7seg_pkg.sv @@
// Shared types, font and radix power tables for the seven-segment converter.
package sn7seg_pkg;

   localparam int unsigned NUM_WIDTH   = 32;
   localparam int unsigned RADIX_WIDTH = 5;
   localparam int unsigned REM_WIDTH   = 16;
   localparam int unsigned DIGIT_BITS  = 4;
   localparam int unsigned NUM_DIGITS  = 4;
   localparam int unsigned QUO_WIDTH   = (NUM_DIGITS - 1) * DIGIT_BITS;
   localparam int unsigned NUM_CELLS   = QUO_WIDTH;
   localparam int unsigned SEG_WIDTH   = 8;

   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;

   localparam logic [SEG_WIDTH-1:0] SEG_BLANK = 8'h00;
   localparam logic [SEG_WIDTH-1:0] SEG_MINUS = 8'h40;

   localparam logic [SEG_WIDTH-1:0] FONT [16] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
   };

   // Powers of the radix, indexed by radix 0 to 16.
   localparam logic [8:0] POW2 [17] = '{
      9'd0, 9'd1, 9'd4, 9'd9, 9'd16, 9'd25, 9'd36, 9'd49, 9'd64,
      9'd81, 9'd100, 9'd121, 9'd144, 9'd169, 9'd196, 9'd225, 9'd256
   };
   localparam logic [12:0] POW3 [17] = '{
      13'd0, 13'd1, 13'd8, 13'd27, 13'd64, 13'd125, 13'd216, 13'd343, 13'd512,
      13'd729, 13'd1000, 13'd1331, 13'd1728, 13'd2197, 13'd2744, 13'd3375, 13'd4096
   };
   localparam logic [16:0] POW4 [17] = '{
      17'd0, 17'd1, 17'd16, 17'd81, 17'd256, 17'd625, 17'd1296, 17'd2401,
      17'd4096, 17'd6561, 17'd10000, 17'd14641, 17'd20736, 17'd28561,
      17'd38416, 17'd50625, 17'd65536
   };

   typedef struct packed {
      logic [REM_WIDTH-1:0]   rem;
      logic [RADIX_WIDTH-1:0] radix;
      logic                   neg;
      logic                   err;
      logic [QUO_WIDTH-1:0]   quo;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } stage_type;

endpackage

@@ rtl/sn7seg_front.sv @@
// Entry stage: sign, magnitude and range check of the incoming number.
module sn7seg_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [sn7seg_pkg::NUM_WIDTH-1:0]     number,
   input  logic [sn7seg_pkg::RADIX_WIDTH-1:0]   radix,
   output sn7seg_pkg::stage_type                out,
   input  logic                                 out_ready
);
   import sn7seg_pkg::*;

   logic                   valid_ff;
   work_type               work_ff;
   work_type               work_in;
   logic                   radix_ok;
   logic [RADIX_WIDTH-1:0] radix_idx;
   logic [12:0]            p3;
   logic [16:0]            p4;
   logic                   neg;
   logic                   is_zero;
   logic                   too_neg;
   logic                   too_big;

   always_comb begin
      radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
      // An unsupported radix is swapped for the smallest one, so that a zero
      // still passes through the cells against a non-zero divisor.
      radix_idx = radix_ok ? radix : RADIX_MIN;
      p3        = POW3[radix_idx];
      p4        = POW4[radix_idx];
      neg       = number[NUM_WIDTH-1];
      is_zero   = (number == '0);
      // A negative number must leave one position for the minus sign.
      too_neg   = neg && ($signed(number) <= -$signed({19'd0, p3}));
      too_big   = !neg && (number >= {15'd0, p4});

      work_in.rem   = neg ? REM_WIDTH'(~number[REM_WIDTH-1:0] + 16'd1)
                          : number[REM_WIDTH-1:0];
      work_in.radix = radix_idx;
      work_in.neg   = neg;
      work_in.err   = !is_zero && (!radix_ok || too_neg || too_big);
      work_in.quo   = '0;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out.valid = valid_ff;
   assign out.work  = work_ff;

endmodule

@@ rtl/sn7seg_cell.sv @@
// One restoring-division cell: settles a single quotient bit of one digit.
module sn7seg_cell #(
   parameter int unsigned LEVEL = 3,
   parameter int unsigned SHIFT = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sn7seg_pkg::stage_type in,
   output logic                  in_ready,
   output sn7seg_pkg::stage_type out,
   input  logic                  out_ready
);
   import sn7seg_pkg::*;

   localparam int unsigned BIT = (LEVEL - 1) * DIGIT_BITS + SHIFT;

   logic        valid_ff;
   work_type    work_ff;
   work_type    work_in;
   logic [12:0] divisor;
   logic [16:0] trial;

   always_comb begin
      if (LEVEL == 3) begin
         divisor = POW3[in.work.radix];
      end else if (LEVEL == 2) begin
         divisor = 13'(POW2[in.work.radix]);
      end else begin
         divisor = 13'(in.work.radix);
      end
      trial   = {4'd0, divisor} << SHIFT;
      work_in = in.work;
      if ({1'b0, in.work.rem} >= trial) begin
         work_in.rem      = in.work.rem - trial[REM_WIDTH-1:0];
         work_in.quo[BIT] = 1'b1;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in.valid;
      end
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out.valid = valid_ff;
   assign out.work  = work_ff;

endmodule

@@ rtl/sn7seg_fmt.sv @@
// Output stage: blanking, minus placement, font lookup and result register.
module sn7seg_fmt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sn7seg_pkg::stage_type                in,
   output logic                                 in_ready,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [4*sn7seg_pkg::SEG_WIDTH-1:0]   segs,
   output logic                                 err
);
   import sn7seg_pkg::*;

   logic                                 valid_ff;
   logic [NUM_DIGITS-1:0][SEG_WIDTH-1:0] seg_ff;
   logic [NUM_DIGITS-1:0][SEG_WIDTH-1:0] seg_in;
   logic                                 err_ff;
   logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digit;
   logic [NUM_DIGITS-1:0]                shown;
   logic [NUM_DIGITS-1:0]                minus;

   always_comb begin
      digit[0] = in.work.quo[11:8];
      digit[1] = in.work.quo[7:4];
      digit[2] = in.work.quo[3:0];
      digit[3] = in.work.rem[DIGIT_BITS-1:0];

      // The rightmost digit is always shown, which also gives '0' for zero.
      shown[0] = (digit[0] != '0);
      shown[1] = shown[0] || (digit[1] != '0);
      shown[2] = shown[1] || (digit[2] != '0);
      shown[3] = 1'b1;

      minus[0] = in.work.neg && shown[1] && !shown[0];
      minus[1] = in.work.neg && shown[2] && !shown[1];
      minus[2] = in.work.neg && !shown[2];
      minus[3] = 1'b0;

      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (in.work.err) begin
            seg_in[i] = SEG_BLANK;
         end else if (shown[i]) begin
            seg_in[i] = FONT[digit[i]];
         end else if (minus[i]) begin
            seg_in[i] = SEG_MINUS;
         end else begin
            seg_in[i] = SEG_BLANK;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in.valid;
      end
      if (in_ready) begin
         seg_ff <= seg_in;
         err_ff <= in.work.err;
      end
   end

   assign out_valid = valid_ff;
   assign err       = err_ff;

   // Leftmost digit goes to the lowest byte.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         segs[i*SEG_WIDTH +: SEG_WIDTH] = seg_ff[i];
      end
   end

endmodule

@@ rtl/signed_number_to_seven_segment.sv @@
// Top level of the signed number to four-digit seven-segment converter.
//
//   Channel   Direction  tdata                               tuser
//   req       in         number[31:0], radix[36:32]          -
//   rsp       out        seg_digit0..seg_digit3, 8 bits each out_of_range
//
// Each item passes from req to rsp through one entry stage, twelve division
// cells (four quotient bits for each of the three upper digits, one cell per
// bit) and the output register. The chain accepts one item per cycle while
// rsp is not stalled and holds up to 14 items in flight.
// Reset is synchronous and clears only the valid bits of the stages.
// A stall on rsp backs up stage by stage; a stage that holds no item keeps
// taking new work, so bubbles in the chain are squeezed out.
module signed_number_to_seven_segment (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // number[31:0], radix[36:32], zero[39:37]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // seg_digit0[7:0], seg_digit1[15:8],
                                   // seg_digit2[23:16], seg_digit3[31:24]
   output logic [0:0]  rsp_tuser   // out_of_range[0]
);
   import sn7seg_pkg::*;

   // stage[k] is the item leaving stage k; rdy[k] says its consumer can take it.
   stage_type stage [NUM_CELLS+1];
   logic      rdy   [NUM_CELLS+1];

   // Sign, magnitude and range check are settled in the entry stage, so the
   // cells only ever divide a 16-bit magnitude.
   sn7seg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .number    (req_tdata[NUM_WIDTH-1:0]),
      .radix     (req_tdata[NUM_WIDTH +: RADIX_WIDTH]),
      .out       (stage[0]),
      .out_ready (rdy[0])
   );

   // Digits are taken most significant first by restoring division against
   // radix^3, radix^2 and radix; what is left after the last cell is the
   // rightmost digit.
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      sn7seg_cell #(
         .LEVEL (3 - g / DIGIT_BITS),
         .SHIFT (DIGIT_BITS - 1 - g % DIGIT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in        (stage[g]),
         .in_ready  (rdy[g]),
         .out       (stage[g+1]),
         .out_ready (rdy[g+1])
      );
   end

   sn7seg_fmt u_fmt (
      .clock     (clock),
      .reset     (reset),
      .in        (stage[NUM_CELLS]),
      .in_ready  (rdy[NUM_CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .segs      (rsp_tdata),
      .err       (rsp_tuser[0])
   );

endmodule

@@ rtl/sn7seg_checker.sv @@
// Port-level checks for the converter, bound to its top level.
module sn7seg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // An out-of-range result carries all-blank segments.
   a_err_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("out_of_range result with non-zero segments");

   // A valid number always lights its rightmost digit.
   a_last_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:24] != 8'd0)
      else $error("rightmost digit blank on an in-range result");

   // The decimal points are never driven.
   a_no_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7] && !rsp_tdata[15] && !rsp_tdata[23] && !rsp_tdata[31])
      else $error("decimal point set");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule

bind signed_number_to_seven_segment sn7seg_checker u_checker (.*);
